@@ design/pidb_pkg.sv @@
// pidb_pkg: shared widths, types and register indexes of the pi controller core
// depends on nothing; every other design file refers to it by scoped names
`default_nettype none

package pidb_pkg;

    localparam int LEVEL_W   = 16;
    localparam int GAIN_W    = 16;
    localparam int FF_W      = 16;
    localparam int DRIVE_W   = 8;
    localparam int ERR_W     = LEVEL_W + 1;
    localparam int ACC_W     = 40;
    localparam int SUM_W     = 42;
    localparam int FRAC_SHIFT = 13;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [DRIVE_W-1:0] DRIVE_MAX = 8'd255;

    localparam logic [CFG_DATA_W-1:0] PROP_GAIN_RST = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEAD_BAND        = 8'd0,
        REG_DEAD_BAND_ENABLE = 8'd1,
        REG_PROP_GAIN        = 8'd2,
        REG_INTEG_GAIN       = 8'd3
    } t_reg_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0] dead_band;
        logic               dead_band_enable;
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
    } t_cfg;

    typedef struct packed {
        logic [LEVEL_W-1:0]      measured;
        logic [LEVEL_W-1:0]      target;
        logic signed [FF_W-1:0]  feedforward;
    } t_sample;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic               integ_clamped;
    } t_result;

endpackage

`default_nettype wire

@@ design/pidb_if.sv @@
// pidb_if: valid/ready channel interfaces of the pi controller core
// sample input, result output and register write channel; uses pidb_pkg
`default_nettype none

interface pidb_sample_if;
    logic                                   valid;
    logic                                   ready;
    logic [pidb_pkg::LEVEL_W-1:0]           measured;
    logic [pidb_pkg::LEVEL_W-1:0]           target;
    logic signed [pidb_pkg::FF_W-1:0]       feedforward;

    modport source (output valid, measured, target, feedforward, input ready);
    modport sink   (input valid, measured, target, feedforward, output ready);
endinterface

interface pidb_result_if;
    logic                           valid;
    logic                           ready;
    logic [pidb_pkg::DRIVE_W-1:0]   drive;
    logic                           integ_clamped;

    modport source (output valid, drive, integ_clamped, input ready);
    modport sink   (input valid, drive, integ_clamped, output ready);
endinterface

interface pidb_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pidb_pkg::CFG_IDX_W-1:0]     index;
    logic [pidb_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/pidb_cfg_regs.sv @@
// pidb_cfg_regs: controller register file written over the config channel
// uses pidb_pkg and pidb_cfg_if
`default_nettype none

module pidb_cfg_regs (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    pidb_cfg_if.sink            i_cfg,
    output pidb_pkg::t_cfg      o_cfg
);

    pidb_pkg::t_cfg r_cfg;
    pidb_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                pidb_pkg::REG_DEAD_BAND:        n_cfg.dead_band        = i_cfg.data;
                pidb_pkg::REG_DEAD_BAND_ENABLE: n_cfg.dead_band_enable = i_cfg.data[0];
                pidb_pkg::REG_PROP_GAIN:        n_cfg.prop_gain        = i_cfg.data;
                pidb_pkg::REG_INTEG_GAIN:       n_cfg.integ_gain       = i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dead_band        <= '0;
            r_cfg.dead_band_enable <= 1'b1;
            r_cfg.prop_gain        <= pidb_pkg::PROP_GAIN_RST;
            r_cfg.integ_gain       <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ design/pidb_in_reg.sv @@
// pidb_in_reg: input register that holds one sample beat until the step logic takes it
// uses pidb_pkg and pidb_sample_if
`default_nettype none

module pidb_in_reg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    pidb_sample_if.sink         i_sample,
    input  wire logic           i_take,
    output logic                o_valid,
    output pidb_pkg::t_sample   o_item
);

    logic              r_valid;
    logic              n_valid;
    pidb_pkg::t_sample r_item;
    logic              w_accept;

    // a new beat may enter while the held one moves on
    assign i_sample.ready = !r_valid || i_take;
    assign w_accept       = i_sample.valid && i_sample.ready;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.measured    <= i_sample.measured;
            r_item.target      <= i_sample.target;
            r_item.feedforward <= i_sample.feedforward;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ design/pidb_step.sv @@
// pidb_step: one controller update - dead band, p and trapezoid i terms, exact clamp
// holds the integral and previous error state and the result register; uses pidb_pkg
`default_nettype none

module pidb_step (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  pidb_pkg::t_cfg          i_cfg,
    input  pidb_pkg::t_sample       i_item,
    input  wire logic               i_fire,
    output pidb_pkg::t_result       o_result
);

    localparam int EDB_W  = pidb_pkg::ERR_W + 1;
    localparam int P_W    = pidb_pkg::ERR_W + pidb_pkg::GAIN_W + 1;
    localparam int PI_W   = EDB_W + pidb_pkg::GAIN_W + 1;
    localparam int FS     = pidb_pkg::FRAC_SHIFT;
    localparam int TOPZ_W = pidb_pkg::SUM_W - pidb_pkg::DRIVE_W - FS;

    logic signed [pidb_pkg::ACC_W-1:0] r_acc;
    logic signed [pidb_pkg::ERR_W-1:0] r_prev_err;
    pidb_pkg::t_result                 r_result;

    logic signed [pidb_pkg::ERR_W-1:0] w_err_raw;
    logic signed [EDB_W-1:0]           w_err_wide;
    logic signed [EDB_W-1:0]           w_db;
    logic                              w_in_band;
    logic signed [pidb_pkg::ERR_W-1:0] w_err;
    logic [pidb_pkg::DRIVE_W-1:0]      w_ff;
    logic signed [P_W-2:0]             w_prod_p;
    logic signed [P_W-1:0]             w_p;
    logic signed [EDB_W-1:0]           w_err_sum;
    logic signed [PI_W-1:0]            w_prod_i;
    logic signed [pidb_pkg::SUM_W-1:0] w_ui;
    logic signed [pidb_pkg::SUM_W-1:0] w_hi;
    logic signed [pidb_pkg::SUM_W-1:0] w_lo;
    logic signed [pidb_pkg::SUM_W-1:0] w_uc;
    logic                              w_clamped;
    logic signed [pidb_pkg::SUM_W-1:0] w_sum;

    always_comb begin
        w_err_raw  = $signed({1'b0, i_item.target}) - $signed({1'b0, i_item.measured});
        w_err_wide = EDB_W'(w_err_raw);
        w_db       = $signed({2'b00, i_cfg.dead_band});
        // strict test, so a zero margin never zeroes the error
        w_in_band  = i_cfg.dead_band_enable && (w_err_wide < w_db) && (w_err_wide > -w_db);
        w_err      = w_in_band ? '0 : w_err_raw;

        if (i_item.feedforward < 0) begin
            w_ff = '0;
        end else if (i_item.feedforward > $signed({8'd0, pidb_pkg::DRIVE_MAX})) begin
            w_ff = pidb_pkg::DRIVE_MAX;
        end else begin
            w_ff = i_item.feedforward[pidb_pkg::DRIVE_W-1:0];
        end

        // both terms in 2^-13 units
        w_prod_p  = $signed({1'b0, i_cfg.prop_gain}) * w_err;
        w_p       = {w_prod_p, 1'b0};
        w_err_sum = EDB_W'(w_err) + EDB_W'(r_prev_err);
        w_prod_i  = $signed({1'b0, i_cfg.integ_gain}) * w_err_sum;
        w_ui      = pidb_pkg::SUM_W'(r_acc) + pidb_pkg::SUM_W'(w_prod_i);

        w_hi = $signed({{TOPZ_W{1'b0}}, pidb_pkg::DRIVE_MAX - w_ff, {FS{1'b0}}})
               - pidb_pkg::SUM_W'(w_p);
        w_lo = -$signed({{TOPZ_W{1'b0}}, w_ff, {FS{1'b0}}}) - pidb_pkg::SUM_W'(w_p);

        w_uc      = w_ui;
        w_clamped = 1'b0;
        if (w_ui > w_hi) begin
            w_uc      = w_hi;
            w_clamped = 1'b1;
        end else if (w_ui < w_lo) begin
            w_uc      = w_lo;
            w_clamped = 1'b1;
        end

        // after the clamp the sum always lies in 0..255 in integer units
        w_sum = pidb_pkg::SUM_W'(w_p) + w_uc
                + $signed({{TOPZ_W{1'b0}}, w_ff, {FS{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_prev_err <= '0;
        end else if (i_fire) begin
            r_acc      <= w_uc[pidb_pkg::ACC_W-1:0];
            r_prev_err <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_result.drive         <= w_sum[FS+pidb_pkg::DRIVE_W-1:FS];
            r_result.integ_clamped <= w_clamped;
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

@@ design/pi_controller_deadband_antiwindup_core.sv @@
// pi_controller_deadband_antiwindup_core: top level of the pi light controller
// uses pidb_pkg, pidb_if, pidb_cfg_regs, pidb_in_reg and pidb_step
//
// usage:
//   i_sample carries one beat per control sample: measured and target levels
//   (Q12.4) and a signed feedforward drive. o_result returns one beat per
//   sample: the 8-bit drive and a flag set when anti-windup moved the integral.
//   i_cfg writes the dead band, dead band enable, proportional and integral
//   gains by index; it is always ready, and the user must write it only while
//   no sample is in flight; the block itself does not enforce this.
//   a sample accepted into the input register is stepped when the result slot
//   is free or being emptied; o_result.valid rises as the result register loads.
//   throughput: one sample per cycle while o_result.ready is high; the integral
//   and previous error update in the single step that loads the result register.
//   when o_result.ready is low the result is held, one more sample waits in the
//   input register, and i_sample.ready then drops until the result is taken.
//   reset (synchronous, active low) clears the integral, previous error and
//   both valid flags and returns the registers to their defaults.
`default_nettype none

module pi_controller_deadband_antiwindup_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    pidb_sample_if.sink     i_sample,
    pidb_cfg_if.sink        i_cfg,
    pidb_result_if.source   o_result
);

    pidb_pkg::t_cfg    w_cfg;
    pidb_pkg::t_sample w_item;
    pidb_pkg::t_result w_result;
    logic              w_item_valid;
    logic              w_fire;
    logic              r_out_valid;
    logic              n_out_valid;

    pidb_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    pidb_in_reg u_in_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample),
        .i_take   (w_fire),
        .o_valid  (w_item_valid),
        .o_item   (w_item)
    );

    // the held sample moves on when the result slot is free or being emptied
    assign w_fire = w_item_valid && (!r_out_valid || o_result.ready);

    pidb_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_item   (w_item),
        .i_fire   (w_fire),
        .o_result (w_result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.drive         = w_result.drive;
    assign o_result.integ_clamped = w_result.integ_clamped;

endmodule

`default_nettype wire
